// ----- hdl/bsc_pkg.sv -----
package bsc_pkg;

    // store geometry
    localparam int STORE_DEPTH = 1024;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
    // signed search bounds: left up to count, right down to -1
    localparam int PTR_W       = CNT_W + 1;

    // payload field widths
    localparam int KIND_W  = 2;
    localparam int DATA_W  = 32;
    localparam int IDX_W   = 10;
    localparam int PROBE_W = 4;

    localparam logic [PROBE_W-1:0] PROBE_MAX = '1;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_APPEND = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ADDR,
        S_CMP,
        S_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic clear;
        logic append;
        logic start;
        logic issue;
        logic step;
        logic load_out;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic in_range;
        logic hit;
    } t_status;

endpackage

// ----- hdl/bsc_ctrl.sv -----
module bsc_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic [bsc_pkg::KIND_W-1:0]   i_kind,
    input  logic                         i_out_stall,
    input  bsc_pkg::t_status             i_status,
    output logic                         o_in_stall,
    output logic                         o_out_valid,
    output bsc_pkg::t_cmd                o_cmd
);
    import bsc_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    // state and output valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    unique case (i_kind)
                        KIND_CLEAR:  o_cmd.clear  = 1'b1;
                        KIND_APPEND: o_cmd.append = 1'b1;
                        KIND_SEARCH: begin
                            o_cmd.start = 1'b1;
                            n_state     = S_ADDR;
                        end
                        default: ;
                    endcase
                end
            end
            S_ADDR: begin
                if (i_status.in_range) begin
                    o_cmd.issue = 1'b1;
                    n_state     = S_CMP;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_CMP: begin
                o_cmd.step = 1'b1;
                n_state    = i_status.hit ? S_DONE : S_ADDR;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // result stays valid until the consumer takes it
    always_comb begin
        n_out_valid = (r_out_valid && i_out_stall) || o_cmd.load_out;
    end

    assign o_out_valid = r_out_valid;

endmodule

// ----- hdl/bsc_dp.sv -----
module bsc_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  bsc_pkg::t_cmd                    i_cmd,
    input  logic signed [bsc_pkg::DATA_W-1:0] i_item_value,
    output bsc_pkg::t_status                 o_status,
    output logic                             o_found,
    output logic [bsc_pkg::IDX_W-1:0]        o_found_index,
    output logic [bsc_pkg::PROBE_W-1:0]      o_probe_count
);
    import bsc_pkg::*;

    logic signed [DATA_W-1:0]  r_mem [STORE_DEPTH];
    logic        [CNT_W-1:0]   r_count;
    logic signed [DATA_W-1:0]  r_val;
    logic signed [DATA_W-1:0]  r_rdata;
    logic signed [PTR_W-1:0]   r_left;
    logic signed [PTR_W-1:0]   r_right;
    logic signed [PTR_W-1:0]   r_mid;
    logic signed [PTR_W-1:0]   n_mid;
    logic        [PROBE_W-1:0] r_probes;
    logic                      r_hit;
    logic        [ADDR_W-1:0]  r_where;
    logic                      r_out_found;
    logic        [IDX_W-1:0]   r_out_idx;
    logic        [PROBE_W-1:0] r_out_probes;
    logic                      w_full;

    assign w_full = (r_count == CNT_W'(STORE_DEPTH));

    // midpoint of the live range, difference is never negative when in range
    assign n_mid = r_left + ((r_right - r_left) >>> 1);

    assign o_status.in_range = (r_left <= r_right);
    assign o_status.hit      = (r_rdata == r_val);

    // element count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.clear) begin
            r_count <= '0;
        end else if (i_cmd.append && !w_full) begin
            r_count <= r_count + CNT_W'(1);
        end
    end

    // element store: append writes, probe reads
    always_ff @(posedge i_clk) begin
        if (i_cmd.append && !w_full) begin
            r_mem[r_count[ADDR_W-1:0]] <= i_item_value;
        end
        if (i_cmd.issue) begin
            r_rdata <= r_mem[n_mid[ADDR_W-1:0]];
        end
    end

    // search bounds, probe counter and hit capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_val    <= i_item_value;
            r_left   <= '0;
            r_right  <= $signed({1'b0, r_count}) - $signed(PTR_W'(1));
            r_probes <= '0;
            r_hit    <= 1'b0;
            r_where  <= '0;
        end
        if (i_cmd.issue) begin
            r_mid <= n_mid;
        end
        if (i_cmd.step) begin
            if (r_probes != PROBE_MAX) begin
                r_probes <= r_probes + PROBE_W'(1);
            end
            if (r_rdata == r_val) begin
                r_hit   <= 1'b1;
                r_where <= r_mid[ADDR_W-1:0];
            end else if (r_rdata < r_val) begin
                r_left <= r_mid + $signed(PTR_W'(1));
            end else begin
                r_right <= r_mid - $signed(PTR_W'(1));
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_found  <= r_hit;
            r_out_idx    <= IDX_W'(r_where);
            r_out_probes <= r_probes;
        end
    end

    assign o_found       = r_out_found;
    assign o_found_index = r_out_idx;
    assign o_probe_count = r_out_probes;

endmodule

// ----- hdl/binary_search_with_count.sv -----
// sequence: clear and append finish in the accepting cycle; a search walks
// the address and compare states once per probe, P being the probe count
// (at most 11 at 1024 entries), then loads its result register
// flow: one item at a time; input is stalled through the probe loop
// (registered store read, then compare) and until the result is loaded
// reset: synchronous active low; empties the store count and drops any result
module binary_search_with_count (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [bsc_pkg::KIND_W-1:0]        i_kind,
    input  logic signed [bsc_pkg::DATA_W-1:0] i_item_value,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic                              o_found,
    output logic [bsc_pkg::IDX_W-1:0]         o_found_index,
    output logic [bsc_pkg::PROBE_W-1:0]       o_probe_count
);
    import bsc_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    // sequencer
    bsc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_kind      (i_kind),
        .i_out_stall (i_stall),
        .i_status    (w_status),
        .o_in_stall  (o_stall),
        .o_out_valid (o_valid),
        .o_cmd       (w_cmd)
    );

    // store, bounds and result
    bsc_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_item_value  (i_item_value),
        .o_status      (w_status),
        .o_found       (o_found),
        .o_found_index (o_found_index),
        .o_probe_count (o_probe_count)
    );

endmodule

// ----- hdl/bsc_checker.sv -----
module bsc_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic                         o_stall,
    input  logic [bsc_pkg::KIND_W-1:0]   i_kind,
    input  logic                         o_valid,
    input  logic                         o_found,
    input  logic [bsc_pkg::IDX_W-1:0]    o_found_index,
    input  logic [bsc_pkg::PROBE_W-1:0]  o_probe_count
);
    import bsc_pkg::*;

    // no result right after reset
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // a search transaction makes the block busy
    a_search_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_kind == KIND_SEARCH) |=> o_stall)
        else $error("search accepted without going busy");

    // clear, append and unused kinds finish in the accepting cycle
    a_other_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_kind != KIND_SEARCH) |=> !o_stall)
        else $error("non-search transaction left the block busy");

    // a miss reports position zero
    a_miss_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found) |-> (o_found_index == '0))
        else $error("miss with nonzero index");

    // a hit needs at least one probe
    a_hit_probe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_found) |-> (o_probe_count != '0))
        else $error("hit with zero probes");

endmodule

bind binary_search_with_count bsc_checker u_bsc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_stall       (o_stall),
    .i_kind        (i_kind),
    .o_valid       (o_valid),
    .o_found       (o_found),
    .o_found_index (o_found_index),
    .o_probe_count (o_probe_count)
);

// ----- tb/sv/tb_top.sv -----
module tb_top;
    import bsc_pkg::*;

    // kind code the block does not use
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 550;

    typedef struct packed {
        logic               found;
        logic [IDX_W-1:0]   index;
        logic [PROBE_W-1:0] probes;
    } t_search_result;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_valid = 1'b0;
    logic                      o_stall;
    logic [KIND_W-1:0]         i_kind = KIND_CLEAR;
    logic signed [DATA_W-1:0]  i_item_value = '0;
    logic                      o_valid;
    logic                      i_stall = 1'b0;
    logic                      o_found;
    logic [IDX_W-1:0]          o_found_index;
    logic [PROBE_W-1:0]        o_probe_count;

    // mirror of the block's store
    logic signed [DATA_W-1:0]  store_copy [0:STORE_DEPTH-1];
    int                        stored_count = 0;
    t_search_result            pending_results [$];

    int mismatches = 0;
    int random_sent = 0;
    int hold_left = 0;
    bit idling = 1'b1;

    binary_search_with_count dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_kind        (i_kind),
        .i_item_value  (i_item_value),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_found       (o_found),
        .o_found_index (o_found_index),
        .o_probe_count (o_probe_count)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("[binary_search_with_count] ERROR");
        $finish;
    end

    // binary search over the mirrored store
    function automatic t_search_result search_outcome(logic signed [DATA_W-1:0] key);
        t_search_result r;
        int left;
        int right;
        int mid;
        int probes;
        r = '0;
        left = 0;
        right = stored_count - 1;
        probes = 0;
        while (left <= right) begin
            mid = left + (right - left) / 2;
            probes++;
            if (store_copy[mid] == key) begin
                r.found = 1'b1;
                r.index = mid[IDX_W-1:0];
                break;
            end else if (store_copy[mid] < key) begin
                left = mid + 1;
            end else begin
                right = mid - 1;
            end
        end
        r.probes = (probes > int'(PROBE_MAX)) ? PROBE_MAX : probes[PROBE_W-1:0];
        return r;
    endfunction

    // update the mirror for one accepted transaction
    task automatic apply_to_model(logic [KIND_W-1:0] kind, logic signed [DATA_W-1:0] val);
        case (kind)
            KIND_CLEAR: begin
                stored_count = 0;
            end
            KIND_APPEND: begin
                if (stored_count < STORE_DEPTH) begin
                    store_copy[stored_count] = val;
                    stored_count++;
                end
            end
            KIND_SEARCH: begin
                pending_results.push_back(search_outcome(val));
            end
            default: ;
        endcase
    endtask

    // offer one transaction, hold it until accepted; returns at a rising edge
    task automatic send_item(logic [KIND_W-1:0] kind, logic signed [DATA_W-1:0] val);
        if (idling && $urandom_range(0, 99) < 18) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_kind       <= kind;
        i_item_value <= val;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        apply_to_model(kind, val);
        if (kind != KIND_UNUSED) random_sent++;
    endtask

    // result side: check, then pick the stall for the next cycle
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $error("result with no search pending: found %0d index %0d probes %0d",
                       o_found, o_found_index, o_probe_count);
                mismatches++;
            end else begin
                t_search_result exp_r;
                exp_r = pending_results.pop_front();
                if (o_found !== exp_r.found) begin
                    $error("found: expected %0d, got %0d", exp_r.found, o_found);
                    mismatches++;
                end
                if (o_found_index !== exp_r.index) begin
                    $error("found_index: expected %0d, got %0d", exp_r.index, o_found_index);
                    mismatches++;
                end
                if (o_probe_count !== exp_r.probes) begin
                    $error("probe_count: expected %0d, got %0d", exp_r.probes, o_probe_count);
                    mismatches++;
                end
            end
        end
        if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left--;
        end else if (idling && $urandom_range(0, 99) < 18) begin
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // load n ascending elements after a clear
    task automatic load_sorted(int n, bit narrow);
        int vals [$];
        repeat (n) begin
            if (narrow) vals.push_back(int'($urandom_range(0, 60)) - 30);
            else        vals.push_back(int'($urandom()));
        end
        vals.sort();
        send_item(KIND_CLEAR, $urandom());
        foreach (vals[i]) send_item(KIND_APPEND, vals[i]);
    endtask

    // empty store, unused kind, clear on an empty store
    task automatic test_empty_store();
        send_item(KIND_SEARCH, 32'sd0);
        send_item(KIND_UNUSED, 32'sd5);
        send_item(KIND_CLEAR, -32'sd1);
        send_item(KIND_SEARCH, 32'h8000_0000);
    endtask

    // extremes of the element range, hits and misses
    task automatic test_extremes();
        logic signed [DATA_W-1:0] elems [7];
        elems = '{32'h8000_0000, -32'sd1000, -32'sd1, 32'sd0, 32'sd1, 32'sd77, 32'h7fff_ffff};
        foreach (elems[i]) send_item(KIND_APPEND, elems[i]);
        send_item(KIND_SEARCH, 32'h8000_0000);
        send_item(KIND_SEARCH, 32'h7fff_ffff);
        send_item(KIND_SEARCH, 32'sd0);
        send_item(KIND_SEARCH, -32'sd1);
        send_item(KIND_SEARCH, 32'sd77);
        send_item(KIND_SEARCH, 32'h8000_0001);
        send_item(KIND_SEARCH, 32'h7fff_fffe);
        send_item(KIND_SEARCH, 32'sd2);
        send_item(KIND_UNUSED, 32'h7fff_ffff);
        send_item(KIND_CLEAR, 32'sd0);
        send_item(KIND_SEARCH, 32'sd77);
    endtask

    // out-of-order store: whatever the probe path yields
    task automatic test_unsorted();
        send_item(KIND_CLEAR, 32'sd0);
        send_item(KIND_APPEND, 32'sd5);
        send_item(KIND_APPEND, 32'sd3);
        send_item(KIND_APPEND, 32'sd9);
        send_item(KIND_APPEND, 32'sd1);
        send_item(KIND_APPEND, 32'sd7);
        send_item(KIND_SEARCH, 32'sd1);
        send_item(KIND_SEARCH, 32'sd9);
        send_item(KIND_SEARCH, 32'sd3);
        send_item(KIND_SEARCH, 32'sd4);
    endtask

    // fill to capacity, appends past the end are dropped
    task automatic test_full_store();
        send_item(KIND_CLEAR, 32'sd0);
        for (int i = 0; i < STORE_DEPTH; i++) send_item(KIND_APPEND, i * 3 - 1536);
        send_item(KIND_APPEND, 32'sd1_000_000);
        send_item(KIND_APPEND, 32'h7fff_ffff);
        send_item(KIND_SEARCH, 32'sd1_000_000);
        send_item(KIND_SEARCH, 32'h7fff_ffff);
        send_item(KIND_SEARCH, -32'sd1536);
        send_item(KIND_SEARCH, (STORE_DEPTH - 1) * 3 - 1536);
        send_item(KIND_SEARCH, 32'sd0);
        send_item(KIND_SEARCH, 32'sd1);
        send_item(KIND_SEARCH, 32'h8000_0000);
    endtask

    // one random load followed by a burst of searches
    task automatic random_round();
        int n;
        logic signed [DATA_W-1:0] key;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(0, 24);
        load_sorted(n, $urandom_range(0, 2) == 0);
        repeat ($urandom_range(4, 12)) begin
            key = $urandom();
            case ($urandom_range(0, 9))
                0: begin
                    // noise: unused kind or an append that breaks the order
                    if ($urandom_range(0, 1)) send_item(KIND_UNUSED, $urandom());
                    else                      send_item(KIND_APPEND, $urandom());
                end
                1, 2: ;
                3: begin
                    if (stored_count > 0)
                        key = store_copy[$urandom_range(0, stored_count - 1)]
                              + ($urandom_range(0, 1) ? 1 : -1);
                end
                default: begin
                    if (stored_count > 0) key = store_copy[$urandom_range(0, stored_count - 1)];
                end
            endcase
            send_item(KIND_SEARCH, key);
        end
    endtask

    // receiver holds off long while searches keep coming
    task automatic test_backpressure();
        load_sorted(16, 1'b0);
        hold_left = 300;
        repeat (20) send_item(KIND_SEARCH, store_copy[$urandom_range(0, stored_count - 1)]);
    endtask

    // steady flow with no idling on either side
    task automatic test_no_idle();
        idling = 1'b0;
        repeat (3) random_round();
        idling = 1'b1;
    endtask

    task automatic test_random();
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) random_round();
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_store();
        test_extremes();
        test_unsorted();
        test_full_store();
        test_backpressure();
        test_no_idle();
        test_random();
        i_valid <= 1'b0;
        // drain outstanding searches, then watch for strays
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("[binary_search_with_count] OK");
        end else begin
            $display("[binary_search_with_count] ERROR");
        end
        $finish;
    end

endmodule
